// ===== rtl/core/auto_range_histogram_macros.svh =====
// Assertion macros shared by the histogram checker.
`ifndef AUTO_RANGE_HISTOGRAM_MACROS_SVH
`define AUTO_RANGE_HISTOGRAM_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ARH_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ARH_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/arh_pkg.sv =====
// Types and constants of the auto-ranging histogram.
package arh_pkg;

  localparam int unsigned SW  = 16;  // sample width
  localparam int unsigned CQW = 24;  // quotient width of the divider
  localparam int unsigned DVW = 16;  // divisor and remainder width
  localparam int unsigned STW = 5;   // divider step count width

  localparam logic KIND_ADD     = 1'b0;
  localparam logic KIND_COMPUTE = 1'b1;

  typedef struct packed {
    logic                 kind;
    logic signed [15:0]   sample_value;
  } in_word_t;

  typedef struct packed {
    logic [5:0]           bin_index;
    logic signed [23:0]   bin_center;
    logic [12:0]          bin_tally;
    logic [12:0]          peak_tally;
    logic                 samples_dropped;
    logic                 is_last;
  } out_word_t;

  typedef struct packed {
    logic [DVW-1:0] rem;
    logic [CQW-1:0] lo;
    logic [DVW-1:0] den;
    logic [STW-1:0] steps;
  } div_req_t;

endpackage

// ===== rtl/core/arh_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
module arh_div (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  arh_pkg::div_req_t        req,
  output logic                     done,
  output logic [arh_pkg::CQW-1:0]  quot
);

  logic [arh_pkg::DVW-1:0] rem_r, rem_nxt;
  logic [arh_pkg::CQW-1:0] lo_r, lo_nxt;
  logic [arh_pkg::DVW-1:0] den_r, den_nxt;
  logic [arh_pkg::CQW-1:0] q_r, q_nxt;
  logic [arh_pkg::STW-1:0] cnt_r, cnt_nxt;
  logic                    run_r, run_nxt;
  logic                    done_r, done_nxt;
  logic [arh_pkg::DVW:0]   trial;
  logic [arh_pkg::DVW:0]   diff;
  logic                    ge;

  // The remainder is always below the divisor, so one more bit fits in DVW+1.
  assign trial = {rem_r, lo_r[arh_pkg::CQW-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    lo_nxt   = lo_r;
    den_nxt  = den_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = req.rem;
      lo_nxt  = req.lo;
      den_nxt = req.den;
      q_nxt   = '0;
      cnt_nxt = req.steps;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = ge ? diff[arh_pkg::DVW-1:0] : trial[arh_pkg::DVW-1:0];
      lo_nxt  = {lo_r[arh_pkg::CQW-2:0], 1'b0};
      q_nxt   = {q_r[arh_pkg::CQW-2:0], ge};
      cnt_nxt = cnt_r - arh_pkg::STW'(1);
      if (cnt_r == arh_pkg::STW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    lo_r  <= lo_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== rtl/core/auto_range_histogram.sv =====
// Auto-ranging equal-width histogram: sample store, binning pass and bin readout.
//
// Input channel (in_valid/in_stall/in_word): each word either adds one signed
// sample (kind add) or asks for the histogram (kind compute). Add words are
// taken one per cycle; samples past MAX_SAMPLES are dropped and flagged.
// A compute word stalls the input until its last bin word has been loaded
// into the output register. Binning walks the store sample by sample: one
// store read, one bin-index division of NBW steps in the shared divider
// (skipped when the range is zero) and a read-modify-write of the bin
// counter memory. Readout then runs one 24-step center division per bin.
// A compute with an empty store emits nothing.
// Output channel (out_valid/out_stall/out_word): one word per bin, in index
// order, is_last on the final one. A stalled word holds in the output
// register; work on the next bin keeps running while a finished word waits
// there. Configuration (cfg_valid/cfg_ready/cfg_data) writes bin_count; it
// is always ready and must be written only while the block is idle, which
// the block itself does not enforce. Reset is synchronous and active low.
// After reset the block clears the bin counter memory before taking input.
module auto_range_histogram #(
  parameter int unsigned MAX_SAMPLES = 4096,
  parameter int unsigned MAX_BINS    = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  arh_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output arh_pkg::out_word_t  out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [6:0]          cfg_data
);

  localparam int unsigned CW   = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AW   = $clog2(MAX_SAMPLES);
  localparam int unsigned NBW  = $clog2(MAX_BINS + 1);
  localparam int unsigned BAW  = $clog2(MAX_BINS);
  localparam int unsigned SQW  = CW + 2 * NBW + 2;
  localparam int unsigned PW   = arh_pkg::SW + NBW;
  localparam int unsigned CPW  = arh_pkg::SW + NBW + 1;
  localparam int unsigned DW   = CPW + 7;

  typedef enum logic [10:0] {
    S_CLR  = 11'b000_0000_0001,
    S_LOAD = 11'b000_0000_0010,
    S_SQRT = 11'b000_0000_0100,
    S_RD   = 11'b000_0000_1000,
    S_MUL  = 11'b000_0001_0000,
    S_DIV  = 11'b000_0010_0000,
    S_BRD  = 11'b000_0100_0000,
    S_BWR  = 11'b000_1000_0000,
    S_ERD  = 11'b001_0000_0000,
    S_EDIV = 11'b010_0000_0000,
    S_EOUT = 11'b100_0000_0000
  } state_t;

  state_t                     state_r, state_nxt;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic signed [15:0]         min_r, min_nxt;
  logic signed [15:0]         max_r, max_nxt;
  logic                       ovf_r, ovf_nxt;
  logic [6:0]                 bin_count_r;
  logic [NBW-1:0]             nb_r, nb_nxt;
  logic [15:0]                range_r, range_nxt;
  logic [CW-1:0]              i_r, i_nxt;
  logic [NBW-1:0]             e_r, e_nxt;
  logic [BAW-1:0]             idx_r, idx_nxt;
  logic [BAW-1:0]             clr_r, clr_nxt;
  logic [CW-1:0]              peak_r, peak_nxt;
  logic                       out_valid_r, out_valid_nxt;
  arh_pkg::out_word_t         out_word_r, out_word_nxt;

  // Sample store and bin counter memory, both with registered read data.
  logic [15:0]                store_mem [MAX_SAMPLES];
  logic [15:0]                store_q_r;
  logic                       st_we, st_re;
  logic [CW-1:0]              bin_mem [MAX_BINS];
  logic [CW-1:0]              bin_q_r;
  logic                       b_we, b_re;
  logic [BAW-1:0]             b_waddr, b_raddr;
  logic [CW-1:0]              b_wdata;

  logic                       div_start, div_done;
  arh_pkg::div_req_t          div_req;
  logic [arh_pkg::CQW-1:0]    div_q;

  logic                       in_acc;
  logic                       out_free;
  logic [NBW:0]               sq_root;
  logic [SQW-1:0]             sq_val;
  logic [15:0]                off;
  logic [PW-1:0]              prod;
  logic [NBW:0]               odd;
  logic [CPW-1:0]             cprod;
  logic [DW-1:0]              cnum;
  logic [NBW-1:0]             qidx;
  logic [CW-1:0]              inc;
  logic                       is_last;

  assign in_stall  = (state_r != S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  assign sq_root = (NBW + 1)'(nb_r) + (NBW + 1)'(1);
  assign sq_val  = SQW'(sq_root) * SQW'(sq_root);
  assign off     = 16'(store_q_r - min_r);
  assign prod    = PW'(off) * PW'(nb_r);
  assign odd     = {e_r, 1'b1};
  assign cprod   = CPW'(range_r) * CPW'(odd);
  assign cnum    = {cprod, 7'b0};
  assign qidx    = div_q[NBW-1:0];
  assign inc     = bin_q_r + CW'(1);
  assign is_last = (e_r == nb_r - NBW'(1));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    ovf_nxt       = ovf_r;
    nb_nxt        = nb_r;
    range_nxt     = range_r;
    i_nxt         = i_r;
    e_nxt         = e_r;
    idx_nxt       = idx_r;
    clr_nxt       = clr_r;
    peak_nxt      = peak_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    st_we         = 1'b0;
    st_re         = 1'b0;
    b_we          = 1'b0;
    b_re          = 1'b0;
    b_waddr       = idx_r;
    b_raddr       = idx_r;
    b_wdata       = '0;
    div_start     = 1'b0;
    div_req       = '0;

    unique case (state_r)
      S_CLR: begin
        b_we    = 1'b1;
        b_waddr = clr_r;
        clr_nxt = clr_r + BAW'(1);
        if (clr_r == BAW'(MAX_BINS - 1)) begin
          state_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        if (in_acc) begin
          if (in_word.kind == arh_pkg::KIND_ADD) begin
            if (cnt_r < CW'(MAX_SAMPLES)) begin
              st_we   = 1'b1;
              cnt_nxt = cnt_r + CW'(1);
              if (in_word.sample_value < min_r) min_nxt = in_word.sample_value;
              if (in_word.sample_value > max_r) max_nxt = in_word.sample_value;
            end else begin
              ovf_nxt = 1'b1;
            end
          end else if (cnt_r == '0) begin
            // Nothing stored: only the run state returns to reset.
            min_nxt = 16'sh7FFF;
            max_nxt = 16'sh8000;
            ovf_nxt = 1'b0;
          end else begin
            range_nxt = 16'(max_r - min_r);
            peak_nxt  = '0;
            i_nxt     = '0;
            if (bin_count_r == 7'd0) begin
              nb_nxt    = '0;
              state_nxt = S_SQRT;
            end else begin
              nb_nxt    = (32'(bin_count_r) > 32'(MAX_BINS)) ? NBW'(MAX_BINS)
                                                             : NBW'(bin_count_r);
              state_nxt = S_RD;
            end
          end
        end
      end
      S_SQRT: begin
        // Integer square root by counting up, capped at MAX_BINS.
        if (nb_r < NBW'(MAX_BINS) && sq_val <= SQW'(cnt_r)) begin
          nb_nxt = nb_r + NBW'(1);
        end else begin
          if (nb_r == '0) nb_nxt = NBW'(1);
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        st_re     = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (range_r == '0) begin
          idx_nxt   = '0;
          state_nxt = S_BRD;
        end else begin
          // The top bits of off*nb are already below the range, so only
          // NBW quotient bits remain to be found.
          div_start     = 1'b1;
          div_req.rem   = prod[PW-1:NBW];
          div_req.lo    = {prod[NBW-1:0], {(arh_pkg::CQW - NBW){1'b0}}};
          div_req.den   = range_r;
          div_req.steps = arh_pkg::STW'(NBW);
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          idx_nxt   = (qidx >= nb_r) ? BAW'(nb_r - NBW'(1)) : BAW'(qidx);
          state_nxt = S_BRD;
        end
      end
      S_BRD: begin
        b_re      = 1'b1;
        state_nxt = S_BWR;
      end
      S_BWR: begin
        b_we    = 1'b1;
        b_wdata = inc;
        if (inc > peak_r) peak_nxt = inc;
        i_nxt = i_r + CW'(1);
        if (i_r + CW'(1) == cnt_r) begin
          e_nxt     = '0;
          state_nxt = S_ERD;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_ERD: begin
        // Center offset is range*(2e+1)*128/nb; its quotient fits 24 bits.
        b_re          = 1'b1;
        b_raddr       = BAW'(e_r);
        div_start     = 1'b1;
        div_req.rem   = arh_pkg::DVW'(cnum[DW-1:arh_pkg::CQW]);
        div_req.lo    = cnum[arh_pkg::CQW-1:0];
        div_req.den   = arh_pkg::DVW'(nb_r);
        div_req.steps = arh_pkg::STW'(arh_pkg::CQW);
        state_nxt     = S_EDIV;
      end
      S_EDIV: begin
        if (div_done) state_nxt = S_EOUT;
      end
      S_EOUT: begin
        if (out_free) begin
          out_valid_nxt                = 1'b1;
          out_word_nxt.bin_index       = 6'(e_r);
          out_word_nxt.bin_center      = {min_r, 8'b0} + div_q;
          out_word_nxt.bin_tally       = 13'(bin_q_r);
          out_word_nxt.peak_tally      = 13'(peak_r);
          out_word_nxt.samples_dropped = ovf_r;
          out_word_nxt.is_last         = is_last;
          // Clearing on readout leaves every counter zero for the next run.
          b_we    = 1'b1;
          b_waddr = BAW'(e_r);
          if (is_last) begin
            cnt_nxt   = '0;
            min_nxt   = 16'sh7FFF;
            max_nxt   = 16'sh8000;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            e_nxt     = e_r + NBW'(1);
            state_nxt = S_ERD;
          end
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (st_we) store_mem[cnt_r[AW-1:0]] <= in_word.sample_value;
    if (st_re) store_q_r <= store_mem[i_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (b_we) bin_mem[b_waddr] <= b_wdata;
    if (b_re) bin_q_r <= bin_mem[b_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      min_r       <= 16'sh7FFF;
      max_r       <= 16'sh8000;
      ovf_r       <= 1'b0;
      bin_count_r <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      nb_r        <= '0;
      i_r         <= '0;
      e_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      min_r       <= min_nxt;
      max_r       <= max_nxt;
      ovf_r       <= ovf_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      nb_r        <= nb_nxt;
      i_r         <= i_nxt;
      e_r         <= e_nxt;
      if (cfg_valid && cfg_ready) bin_count_r <= cfg_data;
    end
    range_r    <= range_nxt;
    idx_r      <= idx_nxt;
    peak_r     <= peak_nxt;
    out_word_r <= out_word_nxt;
  end

  arh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_q)
  );

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== rtl/core/arh_checker.sv =====
// Port-level checker for the histogram, bound to the top level.
`include "auto_range_histogram_macros.svh"

module arh_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input arh_pkg::out_word_t  out_word
);

  `ARH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_word), "stalled output word changed")
  `ARH_ASSERT_NOW(a_tally_le_peak, clk, rst_n, out_valid, out_word.bin_tally <= out_word.peak_tally, "bin tally above peak")
  `ARH_ASSERT_NOW(a_peak_nonzero, clk, rst_n, out_valid, out_word.peak_tally != 13'd0, "peak tally is zero")
  `ARH_ASSERT_NOW(a_busy_mid_run, clk, rst_n, out_valid && !out_word.is_last, in_stall, "input open during readout")

endmodule

bind auto_range_histogram arh_checker u_arh_checker (.*);

// ===== bench/tb_auto_range_histogram.sv =====
// Self-checking testbench for the auto-ranging equal-width histogram.
`timescale 1ns / 1ps

module tb_auto_range_histogram;

  localparam int unsigned CAPACITY    = 4096;
  localparam int unsigned BIN_LIMIT   = 64;
  localparam int unsigned CYCLE_CAP   = 4000000;
  localparam int unsigned SETTLE      = 300;
  localparam int unsigned TOTAL_WORDS = 410;

  // The histogram predictor and the queue of bin words it still expects.
  class hist_scoreboard;
    logic signed [15:0]  samples[$];
    int                  lo_val;
    int                  hi_val;
    bit                  lost;
    bit [6:0]            bins_reg;
    arh_pkg::out_word_t  bins_due[$];
    int                  errors;

    function new();
      bins_reg = '0;
      errors = 0;
      clear_run();
    endfunction

    function void clear_run();
      samples.delete();
      lo_val = 32767;
      hi_val = -32768;
      lost = 1'b0;
    endfunction

    function void set_bins(bit [6:0] v);
      bins_reg = v;
    endfunction

    function int pending();
      return bins_due.size();
    endfunction

    // Note one accepted input word and queue the bin words it causes.
    function void note_input(arh_pkg::in_word_t w);
      int unsigned nb, spread, peak, k, idx;
      int unsigned tally[BIN_LIMIT];
      longint unsigned off, frac;
      longint center;
      arh_pkg::out_word_t e;
      if (w.kind == arh_pkg::KIND_ADD) begin
        if (samples.size() < CAPACITY) begin
          samples.push_back(w.sample_value);
          if (int'(w.sample_value) < lo_val) lo_val = w.sample_value;
          if (int'(w.sample_value) > hi_val) hi_val = w.sample_value;
        end else begin
          lost = 1'b1;
        end
        return;
      end
      if (samples.size() == 0) begin
        clear_run();
        return;
      end
      nb = bins_reg;
      if (nb == 0) begin
        while ((nb + 1) * (nb + 1) <= samples.size()) nb++;
      end
      if (nb == 0) nb = 1;
      if (nb > BIN_LIMIT) nb = BIN_LIMIT;
      spread = int'(hi_val - lo_val);
      foreach (tally[j]) tally[j] = 0;
      foreach (samples[j]) begin
        idx = 0;
        if (spread != 0) begin
          off = longint'(samples[j]) - lo_val;
          idx = 32'((off * nb) / spread);
          if (idx >= nb) idx = nb - 1;
        end
        tally[idx]++;
      end
      peak = 0;
      for (k = 0; k < nb; k++) if (tally[k] > peak) peak = tally[k];
      for (k = 0; k < nb; k++) begin
        frac = (longint'(spread) * (2 * k + 1) * 128) / nb;
        center = longint'(lo_val) * 256 + longint'(frac);
        e.bin_index = k[5:0];
        e.bin_center = center[23:0];
        e.bin_tally = tally[k][12:0];
        e.peak_tally = peak[12:0];
        e.samples_dropped = lost;
        e.is_last = (k + 1 == nb);
        bins_due.push_back(e);
      end
      clear_run();
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
      errors++;
    endtask

    // Compare one accepted bin word with the oldest expectation.
    task check_result(arh_pkg::out_word_t w);
      arh_pkg::out_word_t e;
      if (bins_due.size() == 0) begin
        report("unexpected bin word, index", w.bin_index, -1);
        return;
      end
      e = bins_due.pop_front();
      if (w.bin_index != e.bin_index) report("bin_index", w.bin_index, e.bin_index);
      if (w.bin_center != e.bin_center) report("bin_center", w.bin_center, e.bin_center);
      if (w.bin_tally != e.bin_tally) report("bin_tally", w.bin_tally, e.bin_tally);
      if (w.peak_tally != e.peak_tally) report("peak_tally", w.peak_tally, e.peak_tally);
      if (w.samples_dropped != e.samples_dropped)
        report("samples_dropped", w.samples_dropped, e.samples_dropped);
      if (w.is_last != e.is_last) report("is_last", w.is_last, e.is_last);
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  arh_pkg::in_word_t  in_word = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  arh_pkg::out_word_t out_word;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [6:0]         cfg_data = '0;

  hist_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned sent = 0;
  bit          send_calm = 1'b0;   // When set, the sender never pauses.
  bit          recv_calm = 1'b0;   // When set, the receiver never stalls.
  int unsigned stall_left = 0;
  bit          stall_now = 1'b0;

  auto_range_histogram dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // The run is cut off at a generous cycle count, which counts as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_CAP) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver back-pressure: stretches of stall or flow of random length.
  always @(posedge clk) begin
    if (recv_calm) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      stall_now = ($urandom_range(0, 2) == 0);
      out_stall <= stall_now;
      stall_left <= stall_now ? gap_len() : $urandom_range(0, 6);
    end
  end

  // Values sampled at the edge are the ones the block sees, since all
  // testbench drives are nonblocking.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_word);
  end

  // Offer one word, hold it until taken, then maybe leave a gap.
  task automatic send_word(logic kind, logic [15:0] value);
    arh_pkg::in_word_t w;
    int unsigned g;
    w.kind = kind;
    w.sample_value = value;
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
    sent++;
    g = send_calm ? 0 : gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic add_sample(logic [15:0] value);
    send_word(arh_pkg::KIND_ADD, value);
  endtask

  task automatic compute();
    send_word(arh_pkg::KIND_COMPUTE, 16'($urandom()));
  endtask

  // Wait until every expected bin word has come, then let an empty compute
  // finish its cleanup before anything else happens.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // The register is only written with the block idle.
  task automatic write_bins(logic [6:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_bins(v);
  endtask

  initial begin
    int unsigned n, pick, base, width, k;
    logic [6:0] nb;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // Leave room for the bin counter clearing pass after reset.
    repeat (BIN_LIMIT + 16) @(posedge clk);

    // Directed part: field extremes over four bins.
    write_bins(7'd4);
    add_sample(16'h8000);
    add_sample(16'h7fff);
    add_sample(16'h0000);
    add_sample(16'hffff);
    add_sample(16'h0001);
    add_sample(16'h5555);
    add_sample(16'haaaa);
    compute();
    // A compute with nothing stored emits nothing.
    compute();
    // Zero range sends everything to the first bin.
    write_bins(7'd3);
    add_sample(16'd5);
    add_sample(16'd5);
    add_sample(16'd5);
    compute();
    // A bin count of zero derives the count from the square root.
    write_bins(7'd0);
    for (k = 0; k < 10; k++) add_sample(16'(k * 7 - 30));
    compute();
    add_sample(16'h1234);
    compute();
    write_bins(7'd1);
    add_sample(16'hff00);
    add_sample(16'h0100);
    compute();
    // Bin counts past the limit saturate.
    write_bins(7'd127);
    add_sample(16'h8000);
    add_sample(16'h7fff);
    add_sample(16'h0);
    compute();
    write_bins(7'd64);
    add_sample(16'h8000);
    add_sample(16'h7fff);
    compute();
    // The sender waits out every pending bin word here.
    drain();

    // Random part: sample sets of random content, mostly small, then compute.
    while (sent < TOTAL_WORDS) begin
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 9);
        if (pick == 0) nb = 7'd0;
        else if (pick == 1) nb = 7'd64;
        else if (pick == 2) nb = 7'd127;
        else if (pick == 3) nb = 7'd1;
        else if (pick < 8) nb = 7'($urandom_range(0, 8));
        else nb = 7'($urandom_range(9, 127));
        write_bins(nb);
      end
      send_calm = ($urandom_range(0, 4) == 0);
      recv_calm = ($urandom_range(0, 4) == 0);
      n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 30);
      pick = $urandom_range(0, 3);
      base = $urandom();
      width = (pick == 0) ? 0 : (pick == 1) ? 16 : (pick == 2) ? 1024 : 65536;
      for (k = 0; k < n; k++) begin
        if (width == 65536) add_sample(16'($urandom()));
        else if (width == 0) add_sample(base[15:0]);
        else add_sample(16'(base[15:0] + $urandom_range(0, width - 1)));
      end
      compute();
      if ($urandom_range(0, 7) == 0) drain();
    end
    send_calm = 1'b0;
    recv_calm = 1'b0;

    drain();
    repeat (SETTLE) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
